FILE: rtl/u8bmp_pkg.sv
package u8bmp_pkg;

    // decoder phase between bytes
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_TWO_LAST   = 2'd1,
        PH_THREE_MID  = 2'd2,
        PH_THREE_LAST = 2'd3
    } phase_t;

    // byte class masks and patterns
    localparam logic [7:0] ASCII_MASK     = 8'h80;
    localparam logic [7:0] CONT_MASK      = 8'hc0;
    localparam logic [7:0] CONT_PATTERN   = 8'h80;
    localparam logic [7:0] LEAD2_MASK     = 8'he0;
    localparam logic [7:0] LEAD2_PATTERN  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK     = 8'hf0;
    localparam logic [7:0] LEAD3_PATTERN  = 8'he0;
    localparam logic [7:0] LEAD2_PAYLOAD  = 8'h1f;
    localparam logic [7:0] LEAD3_PAYLOAD  = 8'h0f;
    localparam logic [7:0] CONT_PAYLOAD   = 8'h3f;

    localparam logic [15:0] REPLACEMENT_RESET = 16'hfffd;

    // result of decoding one word
    typedef struct packed {
        logic        valid;
        logic [15:0] code_point;
        logic        is_error;
    } dec_result_t;

endpackage

FILE: rtl/u8bmp_in_stage.sv
module u8bmp_in_stage
    import u8bmp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // room when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

`ifndef SYNTH
    // a held word that cannot move stays held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !advance |=> valid_reg && $stable(byte_reg))
        else $error("input word lost while stalled");
    // an empty stage always has room
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_ready)
        else $error("empty input stage not ready");
    // the stage only advances a word it holds
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> valid_reg)
        else $error("advance with empty input stage");
`endif

endmodule

FILE: rtl/u8bmp_dec.sv
module u8bmp_dec
    import u8bmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  byte_data,
    input  logic [15:0] replacement,
    output dec_result_t res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] partial_reg;
    logic [15:0] partial_next;

    logic        is_ascii;
    logic        is_cont;
    logic        is_lead2;
    logic        is_lead3;
    logic [5:0]  cont_bits;

    // byte classification
    assign is_ascii  = (byte_data & ASCII_MASK) == 8'h00;
    assign is_cont   = (byte_data & CONT_MASK) == CONT_PATTERN;
    assign is_lead2  = (byte_data & LEAD2_MASK) == LEAD2_PATTERN;
    assign is_lead3  = (byte_data & LEAD3_MASK) == LEAD3_PATTERN;
    assign cont_bits = byte_data[5:0] & CONT_PAYLOAD[5:0];

    // next phase and partial value
    always_comb begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        if (step) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (is_ascii) begin
                        phase_next = PH_IDLE;
                    end else if (is_lead2) begin
                        phase_next   = PH_TWO_LAST;
                        partial_next = {5'd0, byte_data[4:0] & LEAD2_PAYLOAD[4:0], 6'd0};
                    end else if (is_lead3) begin
                        phase_next   = PH_THREE_MID;
                        partial_next = {byte_data[3:0] & LEAD3_PAYLOAD[3:0], 12'd0};
                    end else begin
                        phase_next   = PH_IDLE;
                        partial_next = 16'd0;
                    end
                end
                PH_THREE_MID: begin
                    if (is_cont) begin
                        phase_next   = PH_THREE_LAST;
                        partial_next = partial_reg | {4'd0, cont_bits, 6'd0};
                    end else begin
                        phase_next   = PH_IDLE;
                        partial_next = 16'd0;
                    end
                end
                default: begin
                    phase_next   = PH_IDLE;
                    partial_next = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            partial_reg <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

    // result for the current word
    always_comb begin
        res.valid      = 1'b0;
        res.code_point = replacement;
        res.is_error   = 1'b1;
        case (phase_reg)
            PH_IDLE: begin
                if (is_ascii) begin
                    res.valid      = step;
                    res.code_point = {8'd0, byte_data};
                    res.is_error   = 1'b0;
                end else if (!is_lead2 && !is_lead3) begin
                    res.valid = step;
                end
            end
            PH_THREE_MID: begin
                res.valid = step && !is_cont;
            end
            default: begin
                res.valid = step;
                if (is_cont) begin
                    res.code_point = partial_reg | {10'd0, cont_bits};
                    res.is_error   = 1'b0;
                end
            end
        endcase
    end

`ifndef SYNTH
    // nothing accumulated while idle
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> partial_reg == 16'd0)
        else $error("partial value not clear in idle");
    // a two-byte sequence holds only its five lead bits, in bits 10 to 6
    a_two_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TWO_LAST |-> partial_reg[15:11] == 5'd0 && partial_reg[5:0] == 6'd0)
        else $error("two-byte partial out of range");
    // a middle continuation moves on to the last byte
    a_mid_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_THREE_MID && is_cont |=> phase_reg == PH_THREE_LAST)
        else $error("three-byte sequence lost its place");
    // an error always carries the replacement code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.is_error |-> res.code_point == replacement)
        else $error("error word without replacement code");
`endif

endmodule

FILE: rtl/u8bmp_out_stage.sv
module u8bmp_out_stage
    import u8bmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dec_result_t res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_point,
    output logic        m_is_error
);

    logic        valid_reg;
    logic [15:0] code_point_reg;
    logic        is_error_reg;

    // free when empty or when the held word is taken this cycle
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res.valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            code_point_reg <= res.code_point;
            is_error_reg   <= res.is_error;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = code_point_reg;
    assign m_is_error   = is_error_reg;

`ifndef SYNTH
    // no result is offered while the register is full and stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_free)
        else $error("result arrives at a full output register");
    // a stalled result stays in place
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |=> valid_reg && $stable(code_point_reg)
            && $stable(is_error_reg))
        else $error("stalled result changed");
    // a result offered while free shows up next cycle
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_free && res.valid |=> valid_reg)
        else $error("result not loaded");
`endif

endmodule

FILE: rtl/utf8_bmp_decoder_top.sv
// UTF-8 decoder for the Basic Multilingual Plane: one byte word in, and after
// each byte that completes a one-, two- or three-byte sequence, one 16-bit
// code point out with is_error low. A malformed byte (a stray continuation, a
// lead of four or more bytes, or a non-continuation inside a sequence) yields
// the programmed replacement code with is_error high, is consumed, and returns
// the decoder to idle; lead bytes produce no word. Overlong forms and
// surrogates pass undetected. The block takes one byte per cycle while the
// output is not stalled: a byte is held in the input register, is decoded in
// a single pass against the phase state, and is registered in the output
// register once that register is free. The replacement code resets to 0xFFFD
// and should only be written while no bytes are in flight.
module utf8_bmp_decoder_top
    import u8bmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_point,
    output logic        m_is_error
);

    logic [15:0] replacement_reg;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        out_free;
    logic        advance;
    dec_result_t res;

    // replacement code register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replacement_reg <= REPLACEMENT_RESET;
        end else if (cfg_wr_en) begin
            replacement_reg <= cfg_wr_data;
        end
    end

    // a word is decoded once the output register can take its result
    assign advance = byte_valid && out_free;

    u8bmp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    u8bmp_dec u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .byte_data   (byte_data),
        .replacement (replacement_reg),
        .res         (res)
    );

    u8bmp_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res          (res),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_is_error   (m_is_error)
    );

`ifndef SYNTH
    // the decoder never emits without a word to decode
    a_res_src: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> advance)
        else $error("result without input word");
    // with both sides idle-free, input is always accepted
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled with output draining");
    // replacement code follows a write
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> replacement_reg == $past(cfg_wr_data))
        else $error("replacement write lost");
`endif

endmodule

FILE: dv/utf8_bmp_decoder_top_test.sv
module utf8_bmp_decoder_top_test
    import u8bmp_pkg::*;
();

    localparam int QUIET_LIMIT = 3000;
    localparam int IDLE_PCT    = 22;

    // one decoded code point as the block should deliver it
    typedef struct packed {
        logic [15:0] cp;
        logic        err;
    } code_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_code_point;
    logic        m_is_error;

    logic [7:0]   byte_q[$];
    code_word_t   code_q[$];
    phase_t       seq_phase;
    logic [15:0]  seq_acc;
    logic [15:0]  subst_code;
    logic         calm;
    logic         in_taken = 1'b0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    utf8_bmp_decoder_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_is_error   (m_is_error)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decode one byte against the tracked sequence state
    function automatic void decode_byte(input logic [7:0] b, output logic emit,
                                        output code_word_t w);
        logic cont;
        logic bad;
        cont = (b & CONT_MASK) == CONT_PATTERN;
        bad  = 1'b0;
        emit = 1'b0;
        w    = '0;
        case (seq_phase)
            PH_IDLE: begin
                if ((b & ASCII_MASK) == 8'h00) begin
                    emit = 1'b1;
                    w.cp = {8'h00, b};
                end else if ((b & LEAD2_MASK) == LEAD2_PATTERN) begin
                    seq_acc   = {8'h00, b & LEAD2_PAYLOAD} << 6;
                    seq_phase = PH_TWO_LAST;
                end else if ((b & LEAD3_MASK) == LEAD3_PATTERN) begin
                    seq_acc   = {8'h00, b & LEAD3_PAYLOAD} << 12;
                    seq_phase = PH_THREE_MID;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_THREE_MID: begin
                if (cont) begin
                    seq_acc   = seq_acc | ({8'h00, b & CONT_PAYLOAD} << 6);
                    seq_phase = PH_THREE_LAST;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                if (cont) begin
                    emit      = 1'b1;
                    w.cp      = seq_acc | {8'h00, b & CONT_PAYLOAD};
                    seq_acc   = '0;
                    seq_phase = PH_IDLE;
                end else begin
                    bad = 1'b1;
                end
            end
        endcase
        // malformed byte is swallowed and the decoder falls back to idle
        if (bad) begin
            emit      = 1'b1;
            w.cp      = subst_code;
            w.err     = 1'b1;
            seq_acc   = '0;
            seq_phase = PH_IDLE;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // mix of well-formed sequences with random content, stray bytes and cut sequences
    task automatic queue_random_text(input int n);
        int stop;
        int kind;
        logic [7:0] b;
        stop = byte_q.size() + n;
        while (byte_q.size() < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                byte_q.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 50) begin
                byte_q.push_back(LEAD2_PATTERN | 8'($urandom_range(0, 31)));
                byte_q.push_back(CONT_PATTERN | 8'($urandom_range(0, 63)));
            end else if (kind < 75) begin
                byte_q.push_back(LEAD3_PATTERN | 8'($urandom_range(0, 15)));
                byte_q.push_back(CONT_PATTERN | 8'($urandom_range(0, 63)));
                byte_q.push_back(CONT_PATTERN | 8'($urandom_range(0, 63)));
            end else if (kind < 88) begin
                byte_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    byte_q.push_back(LEAD2_PATTERN | 8'($urandom_range(0, 31)));
                end else begin
                    byte_q.push_back(LEAD3_PATTERN | 8'($urandom_range(0, 15)));
                    if ($urandom_range(0, 1) == 1)
                        byte_q.push_back(CONT_PATTERN | 8'($urandom_range(0, 63)));
                end
                do b = 8'($urandom_range(0, 255));
                while ((b & CONT_MASK) == CONT_PATTERN);
                byte_q.push_back(b);
            end
        end
    endtask

    // wait until nothing is queued, on the bus or outstanding, then let the pipe empty
    task automatic wait_settled();
        while (byte_q.size() != 0 || s_valid || code_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_replacement(input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        subst_code = v;
    endtask

    // byte driver and sink backpressure
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (aresetn && byte_q.size() != 0
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_byte_in <= byte_q.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: check delivered words and predict from accepted bytes
    always @(posedge aclk) begin : monitor
        code_word_t want;
        code_word_t got;
        logic       emit;
        in_taken = s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{cp: m_code_point, err: m_is_error};
                if (code_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word cp=%h err=%b",
                                              got.cp, got.err));
                end else begin
                    want = code_q.pop_front();
                    if (got.cp !== want.cp)
                        report_mismatch($sformatf("code point %h, wanted %h",
                                                  got.cp, want.cp));
                    if (got.err !== want.err)
                        report_mismatch($sformatf("error flag %b, wanted %b",
                                                  got.err, want.err));
                end
            end
            if (in_taken) begin
                decode_byte(s_byte_in, emit, want);
                if (emit)
                    code_q.push_back(want);
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_byte_in   = 8'h00;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'h0000;
        calm        = 1'b0;
        seq_phase   = PH_IDLE;
        seq_acc     = '0;
        subst_code  = REPLACEMENT_RESET;

        // ascii extremes, overlong and top values, surrogate, bad leads, bad continuations
        byte_q = '{8'h00, 8'h7f,
                   8'hc0, 8'h80, 8'hdf, 8'hbf,
                   8'he0, 8'h80, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'hed, 8'ha0, 8'h80,
                   8'h80, 8'hf0, 8'hff,
                   8'hc3, 8'h41, 8'he2, 8'hc3, 8'he2, 8'h82, 8'hff};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        wait_settled();

        write_replacement(16'h0000);
        queue_random_text(130);
        wait_settled();

        // no idling on either side for this stretch
        write_replacement(16'hffff);
        calm = 1'b1;
        queue_random_text(130);
        wait_settled();
        calm = 1'b0;

        write_replacement(16'($urandom_range(0, 65535)));
        queue_random_text(140);
        wait_settled();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/u8bmp_pkg.sv
rtl/u8bmp_in_stage.sv
rtl/u8bmp_dec.sv
rtl/u8bmp_out_stage.sv
rtl/utf8_bmp_decoder_top.sv
dv/utf8_bmp_decoder_top_test.sv
